// File: hdl/imhtq_pkg.sv
package imhtq_pkg;

  localparam int CAPACITY     = 256;
  localparam int HANDLE_COUNT = 1024;
  localparam int HANDLE_W     = 10;
  localparam int DEADLINE_W   = 64;
  localparam int COUNT_W      = 9;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_POP    = 2'd2;

  typedef struct packed {
    logic [1:0]            opcode;
    logic [HANDLE_W-1:0]   event_handle;
    logic [DEADLINE_W-1:0] deadline;
  } req_t;

  typedef struct packed {
    logic                  ok;
    logic [HANDLE_W-1:0]   result_handle;
    logic [DEADLINE_W-1:0] result_deadline;
    logic [COUNT_W-1:0]    entry_count;
  } rsp_t;

  typedef struct packed {
    logic [HANDLE_W-1:0]   handle;
    logic [DEADLINE_W-1:0] deadline;
  } entry_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP,
    ST_DECIDE,
    ST_TAKE_RD,
    ST_TAKE_LAST,
    ST_TAKE_CMP,
    ST_UP,
    ST_UP_CMP,
    ST_DN,
    ST_DN_L,
    ST_DN_R,
    ST_DN_SW,
    ST_PLACE,
    ST_DONE
  } state_t;

  typedef enum logic [3:0] {
    A_NONE,
    A_CLEAR,
    A_LOAD,
    A_LOOKUP,
    A_DECIDE,
    A_TAKE_RD,
    A_TAKE_LAST,
    A_TAKE_CMP,
    A_UP,
    A_UP_CMP,
    A_DN,
    A_DN_L,
    A_DN_R,
    A_DN_SW,
    A_PLACE,
    A_RESP
  } act_t;

  typedef struct packed {
    logic clr_last;
    logic ins_go;
    logic take_go;
    logic last_hit;
    logic e_gt;
    logic e_up;
    logic at_root;
    logic p_gt;
    logic leaf;
    logic has_right;
    logic moved;
    logic rsp_free;
  } sts_t;

endpackage

// File: hdl/imhtq_ram.sv
module imhtq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/imhtq_ctrl.sv
module imhtq_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_ready,
  input  imhtq_pkg::sts_t  sts,
  output imhtq_pkg::act_t  act
);

  imhtq_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= imhtq_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      imhtq_pkg::ST_CLEAR:     if (sts.clr_last) state_next = imhtq_pkg::ST_IDLE;
      imhtq_pkg::ST_IDLE:      if (req_valid) state_next = imhtq_pkg::ST_LOOKUP;
      imhtq_pkg::ST_LOOKUP:    state_next = imhtq_pkg::ST_DECIDE;
      imhtq_pkg::ST_DECIDE: begin
        priority if (sts.ins_go) state_next = imhtq_pkg::ST_UP;
        else if (sts.take_go)    state_next = imhtq_pkg::ST_TAKE_RD;
        else                     state_next = imhtq_pkg::ST_DONE;
      end
      imhtq_pkg::ST_TAKE_RD:   state_next = imhtq_pkg::ST_TAKE_LAST;
      imhtq_pkg::ST_TAKE_LAST: state_next = sts.last_hit ? imhtq_pkg::ST_DONE
                                                         : imhtq_pkg::ST_TAKE_CMP;
      imhtq_pkg::ST_TAKE_CMP: begin
        priority if (sts.e_gt) state_next = imhtq_pkg::ST_DN;
        else if (sts.e_up)     state_next = imhtq_pkg::ST_UP;
        else                   state_next = imhtq_pkg::ST_PLACE;
      end
      imhtq_pkg::ST_UP:     state_next = sts.at_root ? imhtq_pkg::ST_PLACE
                                                     : imhtq_pkg::ST_UP_CMP;
      imhtq_pkg::ST_UP_CMP: state_next = sts.p_gt ? imhtq_pkg::ST_UP : imhtq_pkg::ST_PLACE;
      imhtq_pkg::ST_DN:     state_next = sts.leaf ? imhtq_pkg::ST_PLACE : imhtq_pkg::ST_DN_L;
      imhtq_pkg::ST_DN_L:   state_next = sts.has_right ? imhtq_pkg::ST_DN_R
                                                       : imhtq_pkg::ST_DN_SW;
      imhtq_pkg::ST_DN_R:   state_next = imhtq_pkg::ST_DN_SW;
      imhtq_pkg::ST_DN_SW:  state_next = sts.moved ? imhtq_pkg::ST_DN : imhtq_pkg::ST_PLACE;
      imhtq_pkg::ST_PLACE:  state_next = imhtq_pkg::ST_DONE;
      imhtq_pkg::ST_DONE:   if (sts.rsp_free) state_next = imhtq_pkg::ST_IDLE;
      default:              state_next = imhtq_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    req_ready = 1'b0;
    act       = imhtq_pkg::A_NONE;
    unique case (state)
      imhtq_pkg::ST_CLEAR:     act = imhtq_pkg::A_CLEAR;
      imhtq_pkg::ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) act = imhtq_pkg::A_LOAD;
      end
      imhtq_pkg::ST_LOOKUP:    act = imhtq_pkg::A_LOOKUP;
      imhtq_pkg::ST_DECIDE:    act = imhtq_pkg::A_DECIDE;
      imhtq_pkg::ST_TAKE_RD:   act = imhtq_pkg::A_TAKE_RD;
      imhtq_pkg::ST_TAKE_LAST: act = imhtq_pkg::A_TAKE_LAST;
      imhtq_pkg::ST_TAKE_CMP:  act = imhtq_pkg::A_TAKE_CMP;
      imhtq_pkg::ST_UP:        act = imhtq_pkg::A_UP;
      imhtq_pkg::ST_UP_CMP:    act = imhtq_pkg::A_UP_CMP;
      imhtq_pkg::ST_DN:        act = imhtq_pkg::A_DN;
      imhtq_pkg::ST_DN_L:      act = imhtq_pkg::A_DN_L;
      imhtq_pkg::ST_DN_R:      act = imhtq_pkg::A_DN_R;
      imhtq_pkg::ST_DN_SW:     act = imhtq_pkg::A_DN_SW;
      imhtq_pkg::ST_PLACE:     act = imhtq_pkg::A_PLACE;
      imhtq_pkg::ST_DONE:      if (sts.rsp_free) act = imhtq_pkg::A_RESP;
      default:                 act = imhtq_pkg::A_NONE;
    endcase
  end

endmodule

// File: hdl/imhtq_dp.sv
module imhtq_dp #(
  parameter int CAPACITY     = imhtq_pkg::CAPACITY,
  parameter int HANDLE_COUNT = imhtq_pkg::HANDLE_COUNT
) (
  input  logic             clk,
  input  logic             rst,
  input  imhtq_pkg::req_t  req,
  input  imhtq_pkg::act_t  act,
  output imhtq_pkg::sts_t  sts,
  output logic             rsp_valid,
  input  logic             rsp_ready,
  output imhtq_pkg::rsp_t  rsp
);

  localparam int PW    = $clog2(CAPACITY);
  localparam int MW    = PW + 1;
  localparam int CW    = $clog2(CAPACITY + 1);
  localparam int HAW   = $clog2(HANDLE_COUNT);
  localparam int HW    = imhtq_pkg::HANDLE_W;
  localparam int DW    = imhtq_pkg::DEADLINE_W;
  localparam int CNT_W = imhtq_pkg::COUNT_W;
  localparam int EW    = HW + DW;
  localparam logic [MW-1:0] MARK = '1;

  logic [1:0]    op;
  logic [HW-1:0] h;
  logic [DW-1:0] d;
  logic [HAW-1:0] clr;
  logic [CW-1:0] n;
  logic [PW-1:0] pos;
  logic [PW-1:0] i;
  logic [HW-1:0] eh;
  logic [DW-1:0] ed;
  logic          ok;
  logic [HW-1:0] rh;
  logic [DW-1:0] rd;
  logic [HW-1:0] bh;
  logic [DW-1:0] bd;
  logic [PW-1:0] bpos;
  logic          bsw;

  logic           heap_we;
  logic [PW-1:0]  heap_waddr;
  logic [PW-1:0]  heap_raddr;
  logic [EW-1:0]  heap_wdata;
  logic [EW-1:0]  heap_rdata;
  imhtq_pkg::entry_t heap_q;
  logic           map_we;
  logic [HAW-1:0] map_waddr;
  logic [HAW-1:0] map_raddr;
  logic [MW-1:0]  map_wdata;
  logic [MW-1:0]  map_q;

  logic [CW:0]   lc;
  logic [CW:0]   rc;
  logic [PW-1:0] parent;
  logic          map_valid;
  logic          h_in_range;

  assign heap_q     = imhtq_pkg::entry_t'(heap_rdata);
  assign lc         = {(CW + 1 - PW)'(0), i} * (CW + 1)'(2) + (CW + 1)'(1);
  assign rc         = lc + (CW + 1)'(1);
  assign parent     = PW'((i - PW'(1)) >> 1);
  assign map_valid  = map_q != MARK;
  assign h_in_range = 32'(h) < HANDLE_COUNT;

  imhtq_ram #(.WIDTH(EW), .DEPTH(CAPACITY)) u_heap (
    .clk   (clk),
    .we    (heap_we),
    .waddr (heap_waddr),
    .wdata (heap_wdata),
    .raddr (heap_raddr),
    .rdata (heap_rdata)
  );

  imhtq_ram #(.WIDTH(MW), .DEPTH(HANDLE_COUNT)) u_map (
    .clk   (clk),
    .we    (map_we),
    .waddr (map_waddr),
    .wdata (map_wdata),
    .raddr (map_raddr),
    .rdata (map_q)
  );

  always_comb begin
    sts.clr_last  = clr == HAW'(HANDLE_COUNT - 1);
    sts.ins_go    = (op == imhtq_pkg::OP_INSERT) && (32'(n) < CAPACITY) && h_in_range
                    && !map_valid;
    sts.take_go   = ((op == imhtq_pkg::OP_REMOVE) && h_in_range && map_valid)
                    || ((op == imhtq_pkg::OP_POP) && (n != '0));
    sts.last_hit  = CW'(pos) == CW'(n - CW'(1));
    sts.e_gt      = heap_q.deadline > rd;
    sts.e_up      = (heap_q.deadline < rd) && (pos != '0);
    sts.at_root   = i == '0;
    sts.p_gt      = heap_q.deadline > ed;
    sts.leaf      = lc >= (CW + 1)'(n);
    sts.has_right = rc < (CW + 1)'(n);
    sts.moved     = bsw;
    sts.rsp_free  = !rsp_valid || rsp_ready;
  end

  always_comb begin
    heap_we    = 1'b0;
    heap_waddr = i;
    heap_wdata = {eh, ed};
    heap_raddr = pos;
    map_we     = 1'b0;
    map_waddr  = HAW'(eh);
    map_wdata  = MW'(i);
    map_raddr  = HAW'(h);
    unique case (act)
      imhtq_pkg::A_CLEAR: begin
        map_we    = 1'b1;
        map_waddr = clr;
        map_wdata = MARK;
      end
      imhtq_pkg::A_TAKE_LAST: begin
        heap_raddr = PW'(n - CW'(1));
        map_we     = 1'b1;
        map_waddr  = HAW'(heap_q.handle);
        map_wdata  = MARK;
      end
      imhtq_pkg::A_UP: heap_raddr = parent;
      imhtq_pkg::A_UP_CMP: begin
        heap_we    = sts.p_gt;
        heap_wdata = heap_rdata;
        map_we     = sts.p_gt;
        map_waddr  = HAW'(heap_q.handle);
      end
      imhtq_pkg::A_DN:   heap_raddr = PW'(lc);
      imhtq_pkg::A_DN_L: heap_raddr = PW'(rc);
      imhtq_pkg::A_DN_SW: begin
        heap_we    = bsw;
        heap_wdata = {bh, bd};
        map_we     = bsw;
        map_waddr  = HAW'(bh);
      end
      imhtq_pkg::A_PLACE: begin
        heap_we = 1'b1;
        map_we  = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr       <= '0;
      n         <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (act == imhtq_pkg::A_CLEAR) clr <= clr + HAW'(1);
      if (act == imhtq_pkg::A_RESP) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      if (act == imhtq_pkg::A_DECIDE && sts.ins_go) n <= n + CW'(1);
      if (act == imhtq_pkg::A_TAKE_LAST) n <= n - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    unique case (act)
      imhtq_pkg::A_LOAD: begin
        op <= req.opcode;
        h  <= req.event_handle;
        d  <= req.deadline;
      end
      imhtq_pkg::A_DECIDE: begin
        ok  <= sts.ins_go;
        rh  <= '0;
        rd  <= '0;
        eh  <= h;
        ed  <= d;
        i   <= PW'(n);
        pos <= (op == imhtq_pkg::OP_REMOVE) ? map_q[PW-1:0] : '0;
      end
      imhtq_pkg::A_TAKE_LAST: begin
        ok <= 1'b1;
        rh <= heap_q.handle;
        rd <= heap_q.deadline;
      end
      imhtq_pkg::A_TAKE_CMP: begin
        eh <= heap_q.handle;
        ed <= heap_q.deadline;
        i  <= pos;
      end
      imhtq_pkg::A_UP_CMP: if (sts.p_gt) i <= parent;
      imhtq_pkg::A_DN_L: begin
        if (ed > heap_q.deadline) begin
          bsw  <= 1'b1;
          bh   <= heap_q.handle;
          bd   <= heap_q.deadline;
          bpos <= PW'(lc);
        end else begin
          bsw <= 1'b0;
          bd  <= ed;
        end
      end
      imhtq_pkg::A_DN_R: begin
        if (bd > heap_q.deadline) begin
          bsw  <= 1'b1;
          bh   <= heap_q.handle;
          bd   <= heap_q.deadline;
          bpos <= PW'(rc);
        end
      end
      imhtq_pkg::A_DN_SW: if (bsw) i <= bpos;
      imhtq_pkg::A_RESP: begin
        rsp.ok              <= ok;
        rsp.result_handle   <= rh;
        rsp.result_deadline <= rd;
        rsp.entry_count     <= CNT_W'(n);
      end
      default: ;
    endcase
  end

endmodule

// File: hdl/indexed_min_heap_timer_queue_top.sv
// Indexed min-heap timer queue: insert a handle with a 64-bit deadline, remove a handle,
// or pop the earliest entry; each request word returns one response word with the new
// entry count. After reset the handle position map is swept, all HANDLE_COUNT entries
// (1024 by default), before the first request is taken. A request holds the block, which
// takes no new request until it has responded; a failed one goes from lookup and decide
// straight to the response. A successful request may add a sift through the heap memory
// (one read and one write port): states UP and UP_CMP per level moved up, and DN, DN_L,
// DN_R if there is a right child, and DN_SW per level moved down. The response word is
// registered once the block is done and the previous response word has been taken.
module indexed_min_heap_timer_queue_top #(
  parameter int CAPACITY     = imhtq_pkg::CAPACITY,
  parameter int HANDLE_COUNT = imhtq_pkg::HANDLE_COUNT
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_ready,
  input  imhtq_pkg::req_t req,
  output logic            rsp_valid,
  input  logic            rsp_ready,
  output imhtq_pkg::rsp_t rsp
);

  imhtq_pkg::act_t act;
  imhtq_pkg::sts_t sts;

  imhtq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .sts       (sts),
    .act       (act)
  );

  imhtq_dp #(.CAPACITY(CAPACITY), .HANDLE_COUNT(HANDLE_COUNT)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .act       (act),
    .sts       (sts),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule
